// ----- src/fsq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the FCFS single-server queue.
// No dependencies; used by every module of the block.
package fsq_pkg;

    localparam int FSQ_QUEUE_DEPTH = 16;
    localparam int TICK_W          = 32;
    localparam int SVC_W           = 16;
    localparam int SUM_W           = 48;
    localparam int WAIT_OUT_W      = 5;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 120;

    // one queued job: arrival stamp and service length
    typedef struct packed {
        logic [TICK_W-1:0] arrival;
        logic [SVC_W-1:0]  service;
    } job_t;

    // server -> wait queue
    typedef struct packed {
        logic push;
        logic pop;
        job_t job;
    } q_cmd_t;

    // wait queue -> server
    typedef struct packed {
        logic                  empty;
        logic                  full;
        logic [WAIT_OUT_W-1:0] waiting;
    } q_stat_t;

    typedef struct packed {
        logic                  job_started;
        logic                  job_finished;
        logic [TICK_W-1:0]     finished_wait;
        logic                  arrival_dropped;
        logic [WAIT_OUT_W-1:0] waiting_jobs;
        logic [TICK_W-1:0]     served_total;
        logic [SUM_W-1:0]      wait_total;
    } result_t;

endpackage

// ----- src/fsq_wait_queue.sv -----
`timescale 1ns / 1ps
// Circular FIFO wait queue held in a memory, with head read-ahead and write bypass.
// Depends on fsq_pkg.
module fsq_wait_queue
    import fsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = FSQ_QUEUE_DEPTH
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  q_cmd_t  cmd,
    output q_stat_t stat,
    output job_t    head_job
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W  = ADDR_W + 1;

    job_t mem [QUEUE_DEPTH];

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              byp_reg;
    job_t              byp_data_reg;
    job_t              rd_data_reg;

    logic [PTR_W-1:0]  slot_sum;
    logic [PTR_W-1:0]  head_inc;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W+WAIT_OUT_W-1:0] count_ext;

    always_comb begin
        slot_sum = PTR_W'(head_reg) + PTR_W'(count_reg);
        if (slot_sum >= PTR_W'(QUEUE_DEPTH)) begin
            slot_sum = slot_sum - PTR_W'(QUEUE_DEPTH);
        end
        wr_addr = slot_sum[ADDR_W-1:0];

        head_inc = PTR_W'(head_reg) + PTR_W'(1);
        if (cmd.pop) begin
            head_next = (head_inc >= PTR_W'(QUEUE_DEPTH)) ? '0 : head_inc[ADDR_W-1:0];
        end else begin
            head_next = head_reg;
        end

        count_next = count_reg + CNT_W'(cmd.push) - CNT_W'(cmd.pop);
        count_ext  = (CNT_W+WAIT_OUT_W)'(count_next);

        stat.empty   = (count_reg == '0);
        stat.full    = (count_reg == CNT_W'(QUEUE_DEPTH));
        stat.waiting = count_ext[WAIT_OUT_W-1:0];

        // an item pushed into an empty queue is the head at once
        if (stat.empty) begin
            head_job = cmd.job;
        end else if (byp_reg) begin
            head_job = byp_data_reg;
        end else begin
            head_job = rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wr_addr] <= cmd.job;
        end
        rd_data_reg  <= mem[head_next];
        byp_data_reg <= cmd.job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            byp_reg   <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            // read of the slot being written returns old data: forward it
            byp_reg   <= cmd.push && (wr_addr == head_next);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("wait queue count above depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full |-> !cmd.push)
        else $error("push into full wait queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.empty && !cmd.push) |-> !cmd.pop)
        else $error("pop from empty wait queue");
`endif

endmodule

// ----- src/fsq_server.sv -----
`timescale 1ns / 1ps
// Tick counter, single server and statistics; one tick resolved per enabled cycle.
// Depends on fsq_pkg; drives fsq_wait_queue through q_cmd_t.
module fsq_server
    import fsq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             arrives,
    input  logic [SVC_W-1:0] service_time,
    input  q_stat_t          q_stat,
    input  job_t             head_job,
    output q_cmd_t           q_cmd,
    output result_t          res
);

    logic [TICK_W-1:0] tick_reg, tick_next;
    logic              busy_reg, busy_next;
    logic [TICK_W-1:0] arrival_reg, arrival_next;
    logic [TICK_W-1:0] start_reg, start_next;
    logic [SVC_W-1:0]  service_reg, service_next;
    logic [TICK_W-1:0] served_reg, served_next;
    logic [SUM_W-1:0]  wsum_reg, wsum_next;

    logic [SVC_W-1:0]  svc;
    logic              avail;
    logic              finish;
    logic [TICK_W-1:0] fwait;
    logic [SUM_W:0]    wsum_add;

    always_comb begin
        svc = (service_time == '0) ? SVC_W'(1) : service_time;

        q_cmd.job.arrival = tick_reg;
        q_cmd.job.service = svc;
        q_cmd.push        = en && arrives && !q_stat.full;

        // a job is there to start if queued or just pushed
        avail  = !q_stat.empty || q_cmd.push;
        finish = en && busy_reg && ((start_reg + TICK_W'(service_reg)) == tick_reg);
        q_cmd.pop = en && avail && (!busy_reg || finish);

        fwait = finish ? (start_reg - arrival_reg) : '0;

        served_next = served_reg;
        if (finish && (served_reg != '1)) begin
            served_next = served_reg + TICK_W'(1);
        end
        wsum_add  = (SUM_W+1)'(wsum_reg) + (SUM_W+1)'(fwait);
        wsum_next = wsum_add[SUM_W] ? '1 : wsum_add[SUM_W-1:0];

        busy_next    = busy_reg;
        arrival_next = arrival_reg;
        start_next   = start_reg;
        service_next = service_reg;
        if (q_cmd.pop) begin
            busy_next    = 1'b1;
            arrival_next = head_job.arrival;
            start_next   = tick_reg;
            service_next = head_job.service;
        end else if (finish) begin
            busy_next = 1'b0;
        end
        tick_next = en ? (tick_reg + TICK_W'(1)) : tick_reg;

        res.job_started     = q_cmd.pop;
        res.job_finished    = finish;
        res.finished_wait   = fwait;
        res.arrival_dropped = en && arrives && q_stat.full;
        res.waiting_jobs    = q_stat.waiting;
        res.served_total    = served_next;
        res.wait_total      = wsum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg    <= '0;
            busy_reg    <= 1'b0;
            arrival_reg <= '0;
            start_reg   <= '0;
            service_reg <= '0;
            served_reg  <= '0;
            wsum_reg    <= '0;
        end else if (en) begin
            tick_reg    <= tick_next;
            busy_reg    <= busy_next;
            arrival_reg <= arrival_next;
            start_reg   <= start_next;
            service_reg <= service_next;
            served_reg  <= served_next;
            wsum_reg    <= wsum_next;
        end
    end

endmodule

// ----- src/fcfs_single_server_queue.sv -----
`timescale 1ns / 1ps
// FCFS single-server queue: one tick per item, input register -> server logic -> result register.
// Result is registered; throughput 1 item per cycle while m_tready does not stall the output.
// The wait queue head is read ahead from its memory, so no stall is needed.
// Reset (aresetn low, synchronous) clears tick count, server, counters and queue pointers;
// queue memory contents are not cleared and no clearing pass is needed.
// Depends on fsq_pkg, fsq_wait_queue and fsq_server.
module fcfs_single_server_queue
    import fsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = FSQ_QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] arrives, [16:1] service_time, [23:17] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] job_started, [1] job_finished, [33:2] finished_wait, [34] arrival_dropped,
    // [39:35] waiting_jobs, [71:40] served_total, [119:72] wait_total
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic             in_valid_reg;
    logic             arrives_reg;
    logic [SVC_W-1:0] service_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    logic    advance;
    logic    proc;
    q_cmd_t  q_cmd;
    q_stat_t q_stat;
    job_t    head_job;
    result_t res;

    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    fsq_wait_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (q_cmd),
        .stat     (q_stat),
        .head_job (head_job)
    );

    fsq_server u_server (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (proc),
        .arrives      (arrives_reg),
        .service_time (service_reg),
        .q_stat       (q_stat),
        .head_job     (head_job),
        .q_cmd        (q_cmd),
        .res          (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (proc) begin
                in_valid_reg <= 1'b0;
            end
            if (proc) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            arrives_reg <= s_tdata[0];
            service_reg <= s_tdata[SVC_W:1];
        end
        if (proc) begin
            out_reg <= res;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_tdata[0]     = out_reg.job_started;
    assign m_tdata[1]     = out_reg.job_finished;
    assign m_tdata[33:2]  = out_reg.finished_wait;
    assign m_tdata[34]    = out_reg.arrival_dropped;
    assign m_tdata[39:35] = out_reg.waiting_jobs;
    assign m_tdata[71:40] = out_reg.served_total;
    assign m_tdata[119:72] = out_reg.wait_total;

`ifndef SYNTHESIS
    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without a pending item");
`endif

endmodule
